FILE: design/assert_macros.svh
// assertion macros shared by the tracker rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is high
`define ART_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds through reset
`define ART_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/art_pkg.sv
// types, codes and constants of the ack retransmit tracker
// no dependencies; imported by art_ctrl, art_dp and the top level
package art_pkg;

   localparam int ART_ENTRIES = 64;

   localparam int MAX_CLIENTS_W = 10;
   localparam int DELAY_W       = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int LIMIT_W       = 15;
   localparam int REQ_DATA_W    = 184;
   localparam int RSP_DATA_W    = 128;

   localparam logic [LIMIT_W-1:0] OVERFLOW_FACTOR = 15'd20;
   localparam logic [2:0]         RETRY_LIMIT     = 3'd7;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_CLIENTS = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY0      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY1      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY2      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY3      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY4      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY5      = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY6      = 3'd7;

   // register reset values
   localparam logic [MAX_CLIENTS_W-1:0] MAX_CLIENTS_RST = 10'd3;
   localparam logic [DELAY_W-1:0] DELAY0_RST = 16'd125;
   localparam logic [DELAY_W-1:0] DELAY1_RST = 16'd250;
   localparam logic [DELAY_W-1:0] DELAY2_RST = 16'd500;
   localparam logic [DELAY_W-1:0] DELAY3_RST = 16'd750;
   localparam logic [DELAY_W-1:0] DELAY4_RST = 16'd1000;
   localparam logic [DELAY_W-1:0] DELAY5_RST = 16'd2000;
   localparam logic [DELAY_W-1:0] DELAY6_RST = 16'd5000;

   typedef enum logic [1:0] {
      REQ_REGISTER = 2'd0,
      REQ_ACK      = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_DUPLICATE   = 3'd1,
      ST_OVERFLOW    = 3'd2,
      ST_ACK_INVALID = 3'd3,
      ST_RESEND      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PUSH_STATUS    = 2'd0,
      PUSH_HOLD_MID  = 2'd1,
      PUSH_HOLD_LAST = 2'd2,
      PUSH_EMPTY     = 2'd3
   } push_src_type;

   typedef struct packed {
      logic [31:0] message_id;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] client_ident;
      logic [7:0]  msg_kind;
      logic [63:0] send_time;
      logic [2:0]  retries;
   } art_entry_type;

   typedef struct packed {
      logic [31:0] message_id;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] client_ident;
      logic [7:0]  msg_kind;
      logic [2:0]  retries;
   } art_resend_type;

   typedef struct packed {
      logic         load;
      logic         advance;
      logic         clr_slot;
      logic         bump;
      logic         insert;
      logic         push;
      push_src_type push_src;
      status_type   status;
   } art_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         cur_valid;
      logic         idx_last;
      logic         hit;
      logic         peer_ok;
      logic         drop;
      logic         due;
      logic         hold_vld;
      logic         out_free;
      logic         can_insert;
   } art_stat_type;

endpackage

FILE: design/art_ram.sv
// generic single write port ram with registered read
// no dependencies
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/art_ctrl.sv
// sequencer of the ack retransmit tracker: slot scan and result pushes
// depends on art_pkg
module art_ctrl
   import art_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  art_stat_type stat,
   output art_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_EVAL   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (stat.kind == REQ_UNUSED) begin
               state_in = S_FINISH;
            end else if (stat.cur_valid) begin
               state_in = S_EVAL;
            end else if (stat.idx_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_EVAL: begin
            case (stat.kind)
               REQ_REGISTER: begin
                  if (stat.hit) begin
                     if (stat.out_free) begin
                        cmd.push     = 1'b1;
                        cmd.push_src = PUSH_STATUS;
                        cmd.status   = ST_DUPLICATE;
                        state_in     = S_IDLE;
                     end
                  end else if (stat.idx_last) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_READ;
                  end
               end
               REQ_ACK: begin
                  if (stat.hit) begin
                     if (stat.out_free) begin
                        cmd.push     = 1'b1;
                        cmd.push_src = PUSH_STATUS;
                        cmd.status   = stat.peer_ok ? ST_OK : ST_ACK_INVALID;
                        cmd.clr_slot = stat.peer_ok;
                        state_in     = S_IDLE;
                     end
                  end else if (stat.idx_last) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_READ;
                  end
               end
               REQ_TICK: begin
                  if (stat.drop || !stat.due || !stat.hold_vld || stat.out_free) begin
                     cmd.clr_slot = stat.drop;
                     if (!stat.drop && stat.due) begin
                        cmd.bump = 1'b1;
                        // previous resend is now known not to be the final one
                        if (stat.hold_vld) begin
                           cmd.push     = 1'b1;
                           cmd.push_src = PUSH_HOLD_MID;
                        end
                     end
                     if (stat.idx_last) begin
                        state_in = S_FINISH;
                     end else begin
                        cmd.advance = 1'b1;
                        state_in    = S_READ;
                     end
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
               case (stat.kind)
                  REQ_REGISTER: begin
                     cmd.push_src = PUSH_STATUS;
                     cmd.insert   = stat.can_insert;
                     cmd.status   = stat.can_insert ? ST_OK : ST_OVERFLOW;
                  end
                  REQ_TICK: begin
                     cmd.push_src = stat.hold_vld ? PUSH_HOLD_LAST : PUSH_EMPTY;
                  end
                  default: begin
                     cmd.push_src = PUSH_STATUS;
                     cmd.status   = ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: design/art_dp.sv
// datapath of the ack retransmit tracker: request latch, slot store, valid bits,
// settings, resend hold and result register; depends on art_pkg, art_ram
module art_dp
   import art_pkg::*;
#(
   parameter int ENTRIES = ART_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  art_cmd_type           cmd,
   output art_stat_type          stat,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // request latch
   req_kind_type kind_ff;
   logic [31:0]  id_ff, ip_ff, cid_ff;
   logic [15:0]  port_ff;
   logic [7:0]   mkind_ff;
   logic [63:0]  now_ff;

   logic [IDX_W-1:0]   idx_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]   count_ff;

   logic [MAX_CLIENTS_W-1:0] max_clients_ff;
   logic [DELAY_W-1:0]       delay_ff [7];

   art_resend_type hold_ff;
   logic           hold_vld_ff;

   logic           rsp_valid_ff;
   status_type     rsp_status_ff;
   art_resend_type rsp_data_ff;
   logic           rsp_last_ff;

   art_entry_type    q, wr_entry;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, free_idx;
   logic             free_any;
   logic [DELAY_W-1:0] delay_sel;
   logic [64:0]      due_at;
   logic [LIMIT_W-1:0] limit;
   logic             out_free;
   art_resend_type   resend_new;

   art_ram #(
      .WIDTH ($bits(art_entry_type)),
      .DEPTH (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (q)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind_type'(req_tuser);
         id_ff    <= req_tdata[31:0];
         ip_ff    <= req_tdata[63:32];
         port_ff  <= req_tdata[79:64];
         cid_ff   <= req_tdata[111:80];
         mkind_ff <= req_tdata[119:112];
         now_ff   <= req_tdata[183:120];
      end
      if (cmd.bump) begin
         hold_ff <= resend_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         valid_ff    <= '0;
         count_ff    <= '0;
         hold_vld_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff      <= '0;
            hold_vld_ff <= 1'b0;
         end else begin
            if (cmd.advance) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (cmd.bump) begin
               hold_vld_ff <= 1'b1;
            end
         end
         if (cmd.clr_slot) begin
            valid_ff[idx_ff] <= 1'b0;
            count_ff         <= count_ff - 1'b1;
         end else if (cmd.insert) begin
            valid_ff[free_idx] <= 1'b1;
            count_ff           <= count_ff + 1'b1;
         end
      end
   end

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         max_clients_ff <= MAX_CLIENTS_RST;
         delay_ff[0]    <= DELAY0_RST;
         delay_ff[1]    <= DELAY1_RST;
         delay_ff[2]    <= DELAY2_RST;
         delay_ff[3]    <= DELAY3_RST;
         delay_ff[4]    <= DELAY4_RST;
         delay_ff[5]    <= DELAY5_RST;
         delay_ff[6]    <= DELAY6_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_CLIENTS: max_clients_ff <= csr_wdata[MAX_CLIENTS_W-1:0];
            CSR_DELAY0:      delay_ff[0]    <= csr_wdata;
            CSR_DELAY1:      delay_ff[1]    <= csr_wdata;
            CSR_DELAY2:      delay_ff[2]    <= csr_wdata;
            CSR_DELAY3:      delay_ff[3]    <= csr_wdata;
            CSR_DELAY4:      delay_ff[4]    <= csr_wdata;
            CSR_DELAY5:      delay_ff[5]    <= csr_wdata;
            CSR_DELAY6:      delay_ff[6]    <= csr_wdata;
            default:         max_clients_ff <= max_clients_ff;
         endcase
      end
   end

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end
   assign free_any = ~&valid_ff;

   always_comb begin
      case (q.retries)
         3'd0:    delay_sel = delay_ff[0];
         3'd1:    delay_sel = delay_ff[1];
         3'd2:    delay_sel = delay_ff[2];
         3'd3:    delay_sel = delay_ff[3];
         3'd4:    delay_sel = delay_ff[4];
         3'd5:    delay_sel = delay_ff[5];
         3'd6:    delay_sel = delay_ff[6];
         default: delay_sel = '0;
      endcase
   end

   assign due_at = {1'b0, q.send_time} + 65'(delay_sel);
   assign limit  = LIMIT_W'(max_clients_ff) * OVERFLOW_FACTOR;

   always_comb begin
      resend_new              = '0;
      resend_new.message_id   = q.message_id;
      resend_new.peer_ip      = q.peer_ip;
      resend_new.peer_port    = q.peer_port;
      resend_new.client_ident = q.client_ident;
      resend_new.msg_kind     = q.msg_kind;
      resend_new.retries      = q.retries + 3'd1;
   end

   always_comb begin
      wr_entry = q;
      wr_addr  = idx_ff;
      wr_en    = cmd.bump | cmd.insert;
      if (cmd.insert) begin
         wr_addr               = free_idx;
         wr_entry.message_id   = id_ff;
         wr_entry.peer_ip      = ip_ff;
         wr_entry.peer_port    = port_ff;
         wr_entry.client_ident = cid_ff;
         wr_entry.msg_kind     = mkind_ff;
         wr_entry.send_time    = now_ff;
         wr_entry.retries      = '0;
      end else begin
         wr_entry.retries = q.retries + 3'd1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat            = '0;
      stat.kind       = kind_ff;
      stat.cur_valid  = valid_ff[idx_ff];
      stat.idx_last   = (idx_ff == IDX_W'(ENTRIES - 1));
      stat.hit        = valid_ff[idx_ff] && (q.message_id == id_ff);
      stat.peer_ok    = (q.peer_ip == ip_ff) && (q.peer_port == port_ff);
      stat.drop       = (q.retries == RETRY_LIMIT);
      stat.due        = ({1'b0, now_ff} > due_at);
      stat.hold_vld   = hold_vld_ff;
      stat.out_free   = out_free;
      stat.can_insert = free_any && (LIMIT_W'(count_ff) <= limit);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         case (cmd.push_src)
            PUSH_STATUS: begin
               rsp_status_ff          <= cmd.status;
               rsp_data_ff            <= '0;
               rsp_data_ff.message_id <= id_ff;
               rsp_last_ff            <= 1'b1;
            end
            PUSH_HOLD_MID: begin
               rsp_status_ff <= ST_RESEND;
               rsp_data_ff   <= hold_ff;
               rsp_last_ff   <= 1'b0;
            end
            PUSH_HOLD_LAST: begin
               rsp_status_ff <= ST_RESEND;
               rsp_data_ff   <= hold_ff;
               rsp_last_ff   <= 1'b1;
            end
            default: begin
               rsp_status_ff <= ST_OK;
               rsp_data_ff   <= '0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff.retries, rsp_data_ff.msg_kind,
                        rsp_data_ff.client_ident, rsp_data_ff.peer_port,
                        rsp_data_ff.peer_ip, rsp_data_ff.message_id};

   `include "assert_macros.svh"

   `ART_ASSERT(a_count_matches_valid, clock, reset, ($countones(valid_ff) == int'(count_ff)), "pending count out of step with valid bits")
   `ART_ASSERT(a_push_into_free, clock, reset, (cmd.push |-> out_free), "result pushed over an untaken result")
   `ART_ASSERT(a_bump_below_limit, clock, reset, (cmd.bump |-> (!stat.drop && kind_ff == REQ_TICK)), "retry bump outside a tick or past the limit")
   `ART_ASSERT_ALWAYS(a_hold_clear_after_load, clock, ((!reset && cmd.load) |=> !hold_vld_ff), "resend hold survives a new request")

endmodule

FILE: design/ack_retransmit_tracker.sv
// top level of the ack retransmit tracker
// depends on art_pkg, art_ctrl, art_dp (which holds the art_ram slot store)
//
// usage
// - req channel: one transfer per request; tuser selects register (0), ack (1),
//   tick (2); tdata carries the message fields and the current time in ms
// - rsp channel: register, ack and unused requests give one transfer; a tick
//   gives one transfer per resend (status resend) in ascending slot order, or a
//   single status-ok transfer when nothing is due; tlast marks the final one
// - csr port: plain write, index 0 is max_clients, 1..7 the seven resend delays;
//   write only while the block is idle
// - timing: requests are handled one at a time; a request is accepted in idle,
//   then its scan checks a free slot in the read state and an occupied slot in
//   the read and evaluate states; the finish state, where reached, pushes the
//   closing result; the walk goes slot by slot through the single-read ram;
//   register and ack stop at the first id match
// - reset: valid bits and the pending count clear at once, settings return to
//   their defaults; no clearing pass over the ram is needed
// - stall: a result waits in the output register; the scan holds while a new
//   result cannot be placed, and the next request is taken once the last result
//   of the current one sits in that register
module ack_retransmit_tracker
   import art_pkg::*;
#(
   parameter int ENTRIES = ART_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // message_id, peer_ip, peer_port, client_ident, msg_kind, now_ms
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]            req_tuser,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_message_id, out_peer_ip, out_peer_port, out_client_ident,
   // out_msg_kind, out_retry_count, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast,
   // settings write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   art_cmd_type  cmd;
   art_stat_type stat;

   art_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   art_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: verif/ack_retransmit_tracker_tb.sv
// self-checking testbench of the ack retransmit tracker
// depends on art_pkg and ack_retransmit_tracker; a local copy of the slot store
// predicts every result, directed tests run first and random traffic follows
module ack_retransmit_tracker_tb;
   import art_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES     = ART_ENTRIES;
   // long enough for the worst request to walk every occupied slot, plus slack
   localparam int SCAN_CYCLES = 2*ENTRIES + 16;
   localparam longint CYCLE_LIMIT = 1500000;

   typedef struct {
      status_type  status;
      logic [31:0] message_id;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] client_ident;
      logic [7:0]  msg_kind;
      logic [2:0]  retries;
      logic        last;
   } rsp_fields_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = REQ_REGISTER;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_MAX_CLIENTS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ack_retransmit_tracker dut (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // local copy of the tracker state
   // ---------------------------------------------------------------
   logic [9:0]  lim_clients;
   logic [15:0] retry_delay [7];
   logic        t_valid  [ENTRIES];
   logic [31:0] t_id     [ENTRIES];
   logic [31:0] t_ip     [ENTRIES];
   logic [15:0] t_port   [ENTRIES];
   logic [31:0] t_cid    [ENTRIES];
   logic [7:0]  t_kind   [ENTRIES];
   logic [63:0] t_sent   [ENTRIES];
   logic [2:0]  t_tries  [ENTRIES];
   int          pending;

   rsp_fields_type awaited_rsp[$];
   int          fails = 0;
   longint      cycles = 0;

   // random traffic knobs
   logic [31:0] id_pool [32];
   logic [63:0] clock_ms = 64'd0;
   int          gap_max = 4;
   int          stall_mode = 0;

   function automatic rsp_fields_type plain_rsp(status_type st, logic [31:0] id);
      rsp_fields_type r;
      r = '{status: st, message_id: id, peer_ip: '0, peer_port: '0,
            client_ident: '0, msg_kind: '0, retries: '0, last: 1'b1};
      return r;
   endfunction

   function automatic int slot_of(logic [31:0] id);
      for (int i = 0; i < ENTRIES; i++)
         if (t_valid[i] && t_id[i] == id) return i;
      return -1;
   endfunction

   // works out the results of one accepted request and updates the copy
   task automatic track_request(req_kind_type kind, logic [31:0] id, logic [31:0] ip,
                                logic [15:0] port, logic [31:0] cid, logic [7:0] mk,
                                logic [63:0] now);
      int s;
      int free_slot;
      int n;
      rsp_fields_type r;
      s = slot_of(id);
      case (kind)
         REQ_REGISTER: begin
            free_slot = -1;
            for (int i = ENTRIES-1; i >= 0; i--)
               if (!t_valid[i]) free_slot = i;
            if (s >= 0)
               awaited_rsp.push_back(plain_rsp(ST_DUPLICATE, id));
            else if (pending > 20*int'(lim_clients) || free_slot < 0)
               awaited_rsp.push_back(plain_rsp(ST_OVERFLOW, id));
            else begin
               t_valid[free_slot] = 1'b1;
               t_id[free_slot]    = id;
               t_ip[free_slot]    = ip;
               t_port[free_slot]  = port;
               t_cid[free_slot]   = cid;
               t_kind[free_slot]  = mk;
               t_sent[free_slot]  = now;
               t_tries[free_slot] = 3'd0;
               pending++;
               awaited_rsp.push_back(plain_rsp(ST_OK, id));
            end
         end
         REQ_ACK: begin
            if (s >= 0 && !(t_ip[s] == ip && t_port[s] == port))
               awaited_rsp.push_back(plain_rsp(ST_ACK_INVALID, id));
            else begin
               if (s >= 0) begin
                  t_valid[s] = 1'b0;
                  if (pending > 0) pending--;
               end
               awaited_rsp.push_back(plain_rsp(ST_OK, id));
            end
         end
         REQ_TICK: begin
            n = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!t_valid[i]) continue;
               if (t_tries[i] == RETRY_LIMIT) begin
                  // exhausted entry leaves without a result
                  t_valid[i] = 1'b0;
                  if (pending > 0) pending--;
                  continue;
               end
               if (now > t_sent[i] && now - t_sent[i] > 64'(retry_delay[t_tries[i]])) begin
                  t_tries[i]++;
                  r = '{status: ST_RESEND, message_id: t_id[i], peer_ip: t_ip[i],
                        peer_port: t_port[i], client_ident: t_cid[i],
                        msg_kind: t_kind[i], retries: t_tries[i], last: 1'b0};
                  awaited_rsp.push_back(r);
                  n++;
               end
            end
            if (n == 0) awaited_rsp.push_back(plain_rsp(ST_OK, 32'd0));
            else awaited_rsp[$].last = 1'b1;
         end
         default: awaited_rsp.push_back(plain_rsp(ST_OK, id));
      endcase
   endtask

   // ---------------------------------------------------------------
   // request side: bursts with random gaps, one transfer per call
   // ---------------------------------------------------------------
   int burst_left = 0;

   task automatic send_req(req_kind_type kind, logic [31:0] id, logic [31:0] ip,
                           logic [15:0] port, logic [31:0] cid, logic [7:0] mk,
                           logic [63:0] now);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tuser  = kind;
      req_tdata  = {now, mk, cid, port, ip, id};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      track_request(kind, id, ip, port, cid, mk, now);
      @(negedge clock);
   endtask

   task automatic go_quiet();
      req_tvalid = 1'b0;
      wait (awaited_rsp.size() == 0);
      // after the last result, wait for a worst-case scan's length
      repeat (SCAN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [15:0] val);
      csr_addr  = idx;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      if (idx == CSR_MAX_CLIENTS) lim_clients = val[9:0];
      else retry_delay[idx - 1] = val;
   endtask

   task automatic write_delays(logic [15:0] d0, logic [15:0] d1, logic [15:0] d2,
                               logic [15:0] d3, logic [15:0] d4, logic [15:0] d5,
                               logic [15:0] d6);
      write_csr(CSR_DELAY0, d0);
      write_csr(CSR_DELAY1, d1);
      write_csr(CSR_DELAY2, d2);
      write_csr(CSR_DELAY3, d3);
      write_csr(CSR_DELAY4, d4);
      write_csr(CSR_DELAY5, d5);
      write_csr(CSR_DELAY6, d6);
   endtask

   // ---------------------------------------------------------------
   // result side: receiver stall pattern and checker
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 2) == 0);
         default: rsp_tready <= (cycles % 7 < 4);
      endcase
   end

   always @(posedge clock) begin
      rsp_fields_type want;
      rsp_fields_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: status_type'(rsp_tuser), message_id: rsp_tdata[31:0],
                 peer_ip: rsp_tdata[63:32], peer_port: rsp_tdata[79:64],
                 client_ident: rsp_tdata[111:80], msg_kind: rsp_tdata[119:112],
                 retries: rsp_tdata[122:120], last: rsp_tlast};
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $realtime, got);
            fails++;
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status || got.message_id !== want.message_id ||
                got.peer_ip !== want.peer_ip || got.peer_port !== want.peer_port ||
                got.client_ident !== want.client_ident ||
                got.msg_kind !== want.msg_kind || got.retries !== want.retries ||
                got.last !== want.last) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected %p", want);
               $display("   actual   %p", got);
               fails++;
            end
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_rsp.size());
         $display("ack_retransmit_tracker test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   // register, duplicate, the ack outcomes, the unused request kind and a tick
   task automatic test_basic_requests();
      send_req(REQ_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
               8'hFF, 64'd1000);
      send_req(REQ_REGISTER, 32'hFFFF_FFFF, 32'd1, 16'd1, 32'd1, 8'd1, 64'd1000);
      send_req(REQ_REGISTER, 32'd0, 32'd0, 16'd0, 32'd0, 8'd0, 64'd0);
      send_req(REQ_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFE, 32'd0, 8'd0, 64'd0);
      send_req(REQ_ACK, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'd0, 8'd0, 64'd0);
      send_req(REQ_ACK, 32'h1234_5678, 32'd0, 16'd0, 32'd0, 8'd0, 64'd0);
      send_req(REQ_UNUSED, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
               8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // only the entry sent at time 0 is due: one resend result
      send_req(REQ_TICK, 32'hDEAD_BEEF, 32'd0, 16'd0, 32'd0, 8'd0, 64'd1000);
      send_req(REQ_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 8'd0, 64'd0);
      send_req(REQ_ACK, 32'd0, 32'd0, 16'd0, 32'd0, 8'd0, 64'd0);
      go_quiet();
   endtask

   // zero delays: every tick resends until seven retries, the next one drops
   task automatic test_retry_exhaust();
      write_delays(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_req(REQ_REGISTER, 32'h0000_0042, 32'hC0A8_0001, 16'd5000, 32'd77, 8'd9,
               64'd0);
      // at the send time itself nothing is due
      send_req(REQ_TICK, 32'd0, 32'd0, 16'd0, 32'd0, 8'd0, 64'd0);
      for (int i = 0; i < 7; i++)
         send_req(REQ_TICK, 32'd0, 32'd0, 16'd0, 32'd0, 8'd0, 64'd1);
      send_req(REQ_TICK, 32'd0, 32'd0, 16'd0, 32'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      go_quiet();
   endtask

   // client limit zero: one entry admitted, the second overflows
   task automatic test_client_limit();
      write_csr(CSR_MAX_CLIENTS, 16'd0);
      send_req(REQ_REGISTER, 32'd10, 32'd1, 16'd1, 32'd1, 8'd1, 64'd5);
      send_req(REQ_REGISTER, 32'd11, 32'd1, 16'd1, 32'd1, 8'd1, 64'd5);
      send_req(REQ_ACK, 32'd10, 32'd1, 16'd1, 32'd0, 8'd0, 64'd0);
      go_quiet();
   endtask

   task automatic rand_item(int reg_pct, int ack_pct, int tick_pct);
      int pick;
      int s;
      logic [31:0] id;
      logic [31:0] ip;
      logic [15:0] port;
      logic [63:0] now;
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 4) == 0) ? $urandom() : id_pool[$urandom_range(0, 31)];
      ip   = $urandom();
      port = 16'($urandom());
      clock_ms += $urandom_range(0, 900);
      now  = ($urandom_range(0, 30) == 0) ? {$urandom(), $urandom()} : clock_ms;
      if (pick < reg_pct)
         send_req(REQ_REGISTER, id, ip, port, $urandom(), 8'($urandom()), now);
      else if (pick < reg_pct + ack_pct) begin
         // mostly ack something that is pending, with the right peer or not
         s = $urandom_range(0, ENTRIES-1);
         if (t_valid[s] && $urandom_range(0, 9) != 0) begin
            id = t_id[s];
            if ($urandom_range(0, 4) != 0) begin
               ip   = t_ip[s];
               port = t_port[s];
            end else if ($urandom_range(0, 1)) ip = t_ip[s];
         end
         send_req(REQ_ACK, id, ip, port, $urandom(), 8'($urandom()), now);
      end else if (pick < reg_pct + ack_pct + tick_pct)
         send_req(REQ_TICK, $urandom(), ip, port, $urandom(), 8'($urandom()), now);
      else
         send_req(REQ_UNUSED, id, ip, port, $urandom(), 8'($urandom()), now);
   endtask

   // default settings, mixed traffic
   task automatic test_random_default(int n);
      for (int i = 0; i < n; i++) rand_item(40, 30, 25);
      go_quiet();
   endtask

   // highest client limit and mostly short delays: store fills up, many resends
   task automatic test_random_full_store(int n);
      write_csr(CSR_MAX_CLIENTS, 16'd1023);
      write_delays(16'd1, 16'd300, 16'd0, 16'd700, 16'd65535, 16'd2, 16'd40);
      for (int i = 0; i < n; i++) rand_item(65, 10, 20);
      go_quiet();
   endtask

   // small client limit and longest delays: overflows and few resends
   task automatic test_random_tight(int n);
      write_csr(CSR_MAX_CLIENTS, 16'd1);
      write_delays(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                   16'd65535, 16'd65535);
      for (int i = 0; i < n; i++) rand_item(45, 25, 25);
      go_quiet();
   endtask

   initial begin
      lim_clients = MAX_CLIENTS_RST;
      retry_delay = '{DELAY0_RST, DELAY1_RST, DELAY2_RST, DELAY3_RST,
                      DELAY4_RST, DELAY5_RST, DELAY6_RST};
      for (int i = 0; i < ENTRIES; i++) t_valid[i] = 1'b0;
      pending = 0;
      foreach (id_pool[i]) id_pool[i] = $urandom();
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_basic_requests();
      test_retry_exhaust();
      test_client_limit();
      stall_mode = 1;
      test_random_default(150);
      stall_mode = 3;
      gap_max = 0;
      test_random_full_store(200);
      stall_mode = 2;
      gap_max = 6;
      test_random_tight(100);
      write_csr(CSR_MAX_CLIENTS, 16'd3);
      write_delays(16'd125, 16'd250, 16'd500, 16'd750, 16'd1000, 16'd2000, 16'd5000);
      stall_mode = 0;
      test_random_default(60);

      if (fails == 0)
         $display("ack_retransmit_tracker test passed");
      else
         $display("ack_retransmit_tracker test failed");
      $finish;
   end

endmodule
